// ----- rtl/core/rtlp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtlp_pkg: shared types and helpers for the route table
// Holds the table size, the command and status codes, the transfer payloads
// and the stored entry layout.
// ----------------------------------------------------------------------------
package rtlp_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned LEN_W = 6;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Request payload.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  device_id;
    logic        mark_gateway;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic [3:0]  out_device;
    logic [31:0] hop_addr;
  } rsp_t;

  // One stored route; len is the number of one bits in the mask.
  typedef struct packed {
    logic [31:0]      network;
    logic [31:0]      mask;
    logic [31:0]      gateway;
    logic [3:0]       device;
    logic             via;
    logic [LEN_W-1:0] len;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Count the one bits of a 32-bit word with a five-level adder tree.
  function automatic logic [LEN_W-1:0] popcount32(input logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  // Low four bits of a table index, zero-extended when the index is narrower.
  function automatic logic [3:0] idx_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] w;
    w = {4'b0000, idx};
    return w[3:0];
  endfunction

endpackage

// ----- rtl/core/rtlp_if.sv -----
// ----------------------------------------------------------------------------
// rtlp_if: valid/ready channels of the route table
// A request channel carrying commands and a response channel carrying results.
// ----------------------------------------------------------------------------

// Command channel.
interface rtlp_req_if;
  import rtlp_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface rtlp_rsp_if;
  import rtlp_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rtlp_ram.sv -----
// ----------------------------------------------------------------------------
// rtlp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module rtlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/route_table_longest_prefix.sv -----
// Flow: the unused command code goes straight to the done state; add and remove scan to their first hit.
// Lookup scans every entry. One command at a time: a new one is accepted once its result
// has been handed to the output register; the scan reads one entry per cycle.
// Reset: every entry is marked down and unwritten at once; unwritten entries read
// as all zero, so no clearing pass is needed and a request is accepted right away.
// ----------------------------------------------------------------------------
// route_table_longest_prefix: IPv4 route table with longest-prefix lookup
// Add takes the first free entry, remove clears the first entry with equal
// network and mask, lookup returns the up entry with the longest matching mask.
// ----------------------------------------------------------------------------
module route_table_longest_prefix (
  input logic         clk_i,
  input logic         rst_ni,
  rtlp_req_if.sink    req_i,
  rtlp_rsp_if.source  rsp_o
);
  import rtlp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e              state_q;
  req_t                req_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [IDX_W-1:0]    ev_idx_q;
  logic                issue_q;
  logic                rd_valid_q;
  logic                up_q      [TABLE_ENTRIES];
  logic                written_q [TABLE_ENTRIES];
  logic                best_valid_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [LEN_W-1:0]    best_len_q;
  logic [3:0]          best_dev_q;
  logic [31:0]         best_hop_q;
  rsp_t                res_q;
  rsp_t                out_q;
  logic                out_valid_q;

  logic                ram_we;
  entry_t              ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              ent;
  logic                last_ev;
  logic                add_hit;
  logic                rem_hit;
  logic                lk_match;
  logic                lk_better;
  logic [31:0]         ent_hop;
  logic                out_free;

  // Entry storage.
  rtlp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ev_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Entry that an add writes.
  always_comb begin
    ram_wdata.network = req_q.address;
    ram_wdata.mask    = req_q.mask;
    ram_wdata.gateway = req_q.gateway;
    ram_wdata.device  = req_q.device_id;
    ram_wdata.via     = req_q.mark_gateway || (req_q.gateway != 32'd0);
    ram_wdata.len     = popcount32(req_q.mask);
  end

  // Evaluation of the entry whose read data is back; unwritten entries read as zero.
  assign ent       = written_q[ev_idx_q] ? entry_t'(ram_rdata) : '0;
  assign last_ev   = (ev_idx_q == LAST_IDX);
  assign add_hit   = !up_q[ev_idx_q];
  assign rem_hit   = (ent.network == req_q.address) && (ent.mask == req_q.mask);
  assign lk_match  = up_q[ev_idx_q] && ((req_q.address & ent.mask) == ent.network);
  assign lk_better = lk_match && (!best_valid_q || (ent.len > best_len_q));
  assign ent_hop   = ent.via ? ent.gateway : req_q.address;

  assign ram_we = (state_q == S_SCAN) && rd_valid_q && (req_q.cmd == CMD_ADD) && add_hit;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || rsp_o.ready;

  // Sequencer, table status bits and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_q      <= 1'b0;
      rd_valid_q   <= 1'b0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        up_q[i]      <= 1'b0;
        written_q[i] <= 1'b0;
      end
    end else begin
      // The output register fills from a finished result and empties on its transfer.
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q        <= req_i.data;
            rd_idx_q     <= '0;
            issue_q      <= 1'b1;
            rd_valid_q   <= 1'b0;
            best_valid_q <= 1'b0;
            if ((req_i.data.cmd == CMD_ADD) || (req_i.data.cmd == CMD_REMOVE) ||
                (req_i.data.cmd == CMD_LOOKUP)) begin
              state_q <= S_SCAN;
            end else begin
              res_q.status      <= ST_MISS;
              res_q.entry_index <= 4'd0;
              res_q.out_device  <= 4'd0;
              res_q.hop_addr    <= 32'd0;
              state_q           <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // Read address pipeline: one entry issued per cycle.
          rd_valid_q <= issue_q;
          ev_idx_q   <= rd_idx_q;
          if (issue_q) begin
            if (rd_idx_q == LAST_IDX) begin
              issue_q <= 1'b0;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end
          if (rd_valid_q) begin
            case (req_q.cmd)
              CMD_ADD: begin
                if (add_hit) begin
                  up_q[ev_idx_q]      <= 1'b1;
                  written_q[ev_idx_q] <= 1'b1;
                  res_q.status        <= ST_OK;
                  res_q.entry_index   <= idx_field(ev_idx_q);
                  res_q.out_device    <= 4'd0;
                  res_q.hop_addr      <= 32'd0;
                  state_q             <= S_DONE;
                end else if (last_ev) begin
                  res_q.status      <= ST_FULL;
                  res_q.entry_index <= 4'd0;
                  res_q.out_device  <= 4'd0;
                  res_q.hop_addr    <= 32'd0;
                  state_q           <= S_DONE;
                end
              end
              CMD_REMOVE: begin
                if (rem_hit) begin
                  up_q[ev_idx_q]    <= 1'b0;
                  res_q.status      <= ST_OK;
                  res_q.entry_index <= idx_field(ev_idx_q);
                  res_q.out_device  <= 4'd0;
                  res_q.hop_addr    <= 32'd0;
                  state_q           <= S_DONE;
                end else if (last_ev) begin
                  res_q.status      <= ST_MISS;
                  res_q.entry_index <= 4'd0;
                  res_q.out_device  <= 4'd0;
                  res_q.hop_addr    <= 32'd0;
                  state_q           <= S_DONE;
                end
              end
              default: begin
                // Lookup keeps the earliest entry with the longest mask.
                if (lk_better) begin
                  best_valid_q <= 1'b1;
                  best_idx_q   <= ev_idx_q;
                  best_len_q   <= ent.len;
                  best_dev_q   <= ent.device;
                  best_hop_q   <= ent_hop;
                end
                if (last_ev) begin
                  state_q <= S_DONE;
                  if (lk_better) begin
                    res_q.status      <= ST_OK;
                    res_q.entry_index <= idx_field(ev_idx_q);
                    res_q.out_device  <= ent.device;
                    res_q.hop_addr    <= ent_hop;
                  end else if (best_valid_q) begin
                    res_q.status      <= ST_OK;
                    res_q.entry_index <= idx_field(best_idx_q);
                    res_q.out_device  <= best_dev_q;
                    res_q.hop_addr    <= best_hop_q;
                  end else begin
                    res_q.status      <= ST_MISS;
                    res_q.entry_index <= 4'd0;
                    res_q.out_device  <= 4'd0;
                    res_q.hop_addr    <= 32'd0;
                  end
                end
              end
            endcase
          end
        end
        S_DONE: begin
          // Hand the result to the output register once it has room.
          if (out_free) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Channel handshakes.
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule
